// ----- rtl/iprd_pkg.sv -----
// Shared constants, state encoding and the digit-to-ASCII helper for the
// radix digit printer. No dependencies.

package iprd_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int DIGIT_DEPTH = 32;

    localparam int DIG_W   = 4;                          // one digit, base up to 16
    localparam int REM_W   = DIG_W + 1;                  // shifted partial remainder
    localparam int IDX_W   = $clog2(DIGIT_DEPTH);
    localparam int CNT_W   = $clog2(DIGIT_DEPTH + 1);
    localparam int STEP_W  = $clog2(VALUE_WIDTH);
    localparam int RADIX_W = 5;
    localparam int CHAR_W  = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;   // '0'
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;   // 'A'
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;   // '-'

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_FORM  = 5'b01000,
        ST_SEND  = 5'b10000
    } state_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIG_W){1'b0}}, d};
        if (d < 4'd10) begin
            digit_char = CHAR_ZERO + ext;
        end else begin
            digit_char = CHAR_A + ext - 8'd10;
        end
    endfunction

endpackage

// ----- rtl/integer_print_radix_digits.sv -----
// Radix digit printer top level: serial restoring divider, digit store and
// character output sequencer. Depends on iprd_pkg.
//
//   channel | dir | tdata            | tuser                          | tlast
//   --------+-----+------------------+--------------------------------+---------------
//   s_      | in  | [31:0] value     | [0] signed_decimal, [5:1] radix | -
//   m_      | out | [7:0] character  | -                              | last character
//
// Timing: each digit is produced by a full pass of the shared shift-subtract
// step over all VALUE_WIDTH bits of the quotient; each digit character then goes
// through store read, format and send, the send holding until m_tready.
// A transaction with an invalid radix in unsigned mode is accepted and produces no output.
// Reset: aresetn is synchronous, active low; it returns the sequencer to idle.
// Stalls: s_tready is high only while idle; a stalled result holds in the
// output registers until m_tready.

module integer_print_radix_digits
    import iprd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_WIDTH-1:0] s_tdata,    // [31:0] value
    input  logic [RADIX_W:0]       s_tuser,    // [0] signed_decimal, [5:1] radix

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [CHAR_W-1:0]      m_tdata,    // [7:0] character
    output logic                   m_tlast     // last character of the number
);

    state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] quot_reg,  quot_next;   // dividend in, quotient out
    logic [REM_W-1:0]       rem_reg,   rem_next;
    logic [RADIX_W-1:0]     base_reg,  base_next;
    logic [STEP_W-1:0]      step_reg,  step_next;
    logic [CNT_W-1:0]       cnt_reg,   cnt_next;    // digits stored so far
    logic [IDX_W-1:0]       idx_reg,   idx_next;    // next digit to print
    logic [CHAR_W-1:0]      char_reg,  char_next;
    logic                   last_reg,  last_next;

    // set when the number being printed carries a leading minus sign
    logic in_sign_reg;

    logic [DIG_W-1:0] digit_mem [DIGIT_DEPTH];
    logic [DIG_W-1:0] rd_reg;
    logic             mem_we;

    // input decode
    logic                   in_acc;
    logic                   in_sgn;
    logic [RADIX_W-1:0]     in_radix;
    logic                   in_neg;
    logic                   in_bad;
    logic [VALUE_WIDTH-1:0] in_mag;

    // one restoring division step
    logic [REM_W-1:0]       rem_sh;
    logic                   q_bit;
    logic [REM_W-1:0]       rem_step;
    logic [VALUE_WIDTH-1:0] quot_step;
    logic                   div_last;
    logic [CNT_W-1:0]       cnt_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_sgn   = s_tuser[0];
    assign in_radix = s_tuser[RADIX_W:1];
    assign in_neg   = in_sgn && s_tdata[VALUE_WIDTH-1];
    assign in_bad   = !in_sgn && ((in_radix < RADIX_MIN) || (in_radix > RADIX_MAX));
    // two's complement magnitude; the most negative value maps onto itself
    assign in_mag   = in_neg ? (~s_tdata[VALUE_WIDTH-1:0] + 1'b1) : s_tdata[VALUE_WIDTH-1:0];

    assign rem_sh    = {rem_reg[REM_W-2:0], quot_reg[VALUE_WIDTH-1]};
    assign q_bit     = (rem_sh >= base_reg);
    assign rem_step  = q_bit ? (rem_sh - base_reg) : rem_sh;
    assign quot_step = {quot_reg[VALUE_WIDTH-2:0], q_bit};
    assign div_last  = (step_reg == STEP_W'(VALUE_WIDTH - 1));
    assign cnt_inc   = cnt_reg + 1'b1;
    assign mem_we    = (state_reg == ST_DIV) && div_last;

    always_comb begin
        state_next = state_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        base_next  = base_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && !in_bad) begin
                    quot_next  = in_mag;
                    rem_next   = '0;
                    base_next  = in_sgn ? RADIX_DEC : in_radix;
                    step_next  = '0;
                    cnt_next   = '0;
                    char_next  = CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = ST_DIV;
                end
                // sign character waits in the output regs until division ends
                if (in_acc && !in_neg) begin
                    char_next = char_reg;
                end
            end
            ST_DIV: begin
                quot_next = quot_step;
                rem_next  = rem_step;
                step_next = step_reg + 1'b1;
                if (div_last) begin
                    // digit written to the store this cycle; restart on the quotient
                    rem_next  = '0;
                    step_next = '0;
                    cnt_next  = cnt_inc;
                    if ((quot_step == '0) || (cnt_inc == CNT_W'(DIGIT_DEPTH))) begin
                        idx_next   = cnt_reg[IDX_W-1:0];
                        state_next = (char_reg == CHAR_MINUS && !last_reg && in_sign_reg)
                                     ? ST_SEND : ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_FORM;
            end
            ST_FORM: begin
                char_next  = digit_char(rd_reg);
                last_next  = (idx_reg == '0);
                idx_next   = idx_reg - 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_tready) begin
                    state_next = last_reg ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_sign_reg <= 1'b0;
            step_reg    <= '0;
            cnt_reg     <= '0;
            last_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            last_reg  <= last_next;
            if (in_acc) begin
                in_sign_reg <= in_neg && !in_bad;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
        idx_reg  <= idx_next;
        char_reg <= char_next;
    end

    // digit store: one write port from the divider, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            digit_mem[cnt_reg[IDX_W-1:0]] <= rem_step[DIG_W-1:0];
        end
        rd_reg <= digit_mem[idx_reg];
    end

    assign m_tvalid = (state_reg == ST_SEND);
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;

    // a radix outside 2..16 in unsigned mode produces nothing
    a_bad_radix_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && in_bad) |=> (state_reg == ST_IDLE))
        else $error("invalid radix started a conversion");

    // the digit count never passes the store depth while dividing
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg < CNT_W'(DIGIT_DEPTH)))
        else $error("digit count overran the store");

    // a non-final character is followed by a store read
    a_next_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (state_reg == ST_FETCH))
        else $error("missing fetch after character");

    // a valid input always starts a conversion
    a_start_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && !in_bad) |=> (state_reg == ST_DIV && cnt_reg == '0))
        else $error("conversion did not start");

    // the divider step counter wraps exactly when a digit is stored
    a_step_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> (step_reg == '0))
        else $error("step counter out of sync");

endmodule
